// ===== hw/rtl/vigenere_70_symbol_cipher_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified assertion forms shared by the cipher RTL.
// ---------------------------------------------------------------------------
`ifndef VIGENERE_70_SYMBOL_CIPHER_MACROS_SVH
`define VIGENERE_70_SYMBOL_CIPHER_MACROS_SVH

// Same-cycle implication.
`define VIG70_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VIG70_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/vig70_pkg.sv =====
// ---------------------------------------------------------------------------
// vig70_pkg
// Alphabet ROM, lookup functions, types and codes of the 70-symbol cipher.
// ---------------------------------------------------------------------------
package vig70_pkg;

    localparam int ALPHA_SIZE = 70;
    localparam int CHAR_W     = 16;
    localparam int IDX_W      = 7;
    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 1;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'b1;

    localparam logic FUNC_KEY_WRITE = 1'b0;
    localparam logic FUNC_DATA      = 1'b1;

    typedef struct packed {
        t_idx idx;
        t_idx shift;
        logic decrypt;
    } t_rot_req;

    localparam t_char ALPHA_ROM [ALPHA_SIZE] = '{
        16'h0041, 16'h2022, 16'h0042, 16'h0043, 16'h2206,
        16'h0044, 16'h0045, 16'h00A0, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C,
        16'h00A3, 16'h004D, 16'h004E, 16'h2014, 16'h004F,
        16'h201D, 16'h0050, 16'h0051, 16'h0052, 16'h0053,
        16'h00E5, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00E8, 16'h00D8,
        16'h0061, 16'h03C0, 16'h0062, 16'h0063, 16'h00CA,
        16'h0064, 16'h0065, 16'h00CD, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C,
        16'h2265, 16'h006D, 16'h006E, 16'h00D2, 16'h006F,
        16'h00DB, 16'h0070, 16'h0071, 16'h0072, 16'h0073,
        16'h00FA, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00FC, 16'h00F8
    };

    // Index of c in the alphabet, ALPHA_SIZE when absent.
    function automatic t_idx alpha_find(t_char c);
        t_idx res;
        res = IDX_W'(ALPHA_SIZE);
        for (int i = ALPHA_SIZE - 1; i >= 0; i--) begin
            if (ALPHA_ROM[i] == c) begin
                res = IDX_W'(i);
            end
        end
        return res;
    endfunction

    function automatic t_char alpha_char(t_idx idx);
        t_char res;
        res = '0;
        for (int i = 0; i < ALPHA_SIZE; i++) begin
            if (idx == IDX_W'(i)) begin
                res = ALPHA_ROM[i];
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/vig70_rotate.sv =====
// ---------------------------------------------------------------------------
// vig70_rotate
// Modulo-70 shift of an alphabet index and mapping back to a character.
// ---------------------------------------------------------------------------
module vig70_rotate (
    input  vig70_pkg::t_rot_req i_req,
    output vig70_pkg::t_char    o_char,
    output logic                o_hit
);

    localparam logic [7:0] SIZE8 = 8'(vig70_pkg::ALPHA_SIZE);

    logic [7:0]      sum;
    vig70_pkg::t_idx wrapped;

    always_comb begin
        if (i_req.decrypt) begin
            sum = {1'b0, i_req.idx} + SIZE8 - {1'b0, i_req.shift};
        end else begin
            sum = {1'b0, i_req.idx} + {1'b0, i_req.shift};
        end
        wrapped = (sum >= SIZE8) ? vig70_pkg::IDX_W'(sum - SIZE8)
                                 : vig70_pkg::IDX_W'(sum);
    end

    assign o_hit  = (i_req.idx < vig70_pkg::IDX_W'(vig70_pkg::ALPHA_SIZE));
    assign o_char = vig70_pkg::alpha_char(wrapped);

endmodule

// ===== hw/rtl/vigenere_70_symbol_cipher.sv =====
// ---------------------------------------------------------------------------
// vigenere_70_symbol_cipher
// Vigenere cipher over a fixed 70-symbol alphabet of 16-bit characters.
// ---------------------------------------------------------------------------
// Takes one beat per clock unless the output stalls and returns one result
// per data beat (key-store read and input register, then rotate and alphabet
// lookup into the output register); key writes produce no result. The key
// store is a one-port-write, one-port-read synchronous memory of KEY_DEPTH
// 7-bit shifts, written at acceptance of a key beat and read at acceptance of
// a data beat, so any mix of the two keeps that rate. Input tuser selects the
// beat type (0 key write, 1 data); tlast on a data beat closes a buffer and
// resets the key position. Unwritten key entries read as garbage.
`include "vigenere_70_symbol_cipher_macros.svh"

module vigenere_70_symbol_cipher #(
    parameter int KEY_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [vig70_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vig70_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] key_slot, [23:8] char_value
    input  logic        s_axis_tuser,  // func
    input  logic        s_axis_tlast,  // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] char_out
    output logic        m_axis_tuser   // in_alphabet
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int PW = (KEY_DEPTH >= 512) ? vig70_pkg::LEN_W : AW;
    localparam int LW = vig70_pkg::LEN_W;

    logic                       r_dir;
    logic [LW-1:0]              r_len;
    logic [PW-1:0]              r_pos;
    logic [PW-1:0]              n_pos;
    logic [vig70_pkg::IDX_W-1:0] r_key_mem [KEY_DEPTH];
    vig70_pkg::t_idx            r_shift;
    logic                       r_s1v;
    vig70_pkg::t_idx            r_s1_idx;
    vig70_pkg::t_char           r_s1_ch;
    logic                       r_ov;
    vig70_pkg::t_char           r_och;
    logic                       r_ohit;

    logic                       acc;
    logic                       acc_key;
    logic                       acc_data;
    logic                       out_en;
    logic                       slot_ok;
    logic [LW-1:0]              eff_len;
    logic [PW-1:0]              pos_eff;
    logic [LW-1:0]              pos_inc;
    vig70_pkg::t_char           in_ch;
    vig70_pkg::t_idx            in_idx;
    vig70_pkg::t_rot_req        rot_req;
    vig70_pkg::t_char           rot_char;
    logic                       rot_hit;

    assign in_ch    = s_axis_tdata[23:8];
    assign in_idx   = vig70_pkg::alpha_find(in_ch);
    assign out_en   = !r_ov || m_axis_tready;
    assign s_axis_tready = i_rst_n && (!r_s1v || out_en);
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign acc_key  = acc && (s_axis_tuser == vig70_pkg::FUNC_KEY_WRITE);
    assign acc_data = acc && (s_axis_tuser == vig70_pkg::FUNC_DATA);
    assign slot_ok  = (32'(s_axis_tdata[7:0]) < 32'(KEY_DEPTH));

    always_comb begin
        if (r_len == '0) begin
            eff_len = LW'(1);
        end else if (32'(r_len) > 32'(KEY_DEPTH)) begin
            eff_len = LW'(KEY_DEPTH);
        end else begin
            eff_len = r_len;
        end
        pos_eff = (LW'(r_pos) >= eff_len) ? '0 : r_pos;
        pos_inc = LW'(pos_eff) + LW'(1);
        if (pos_inc >= eff_len || s_axis_tlast) begin
            n_pos = '0;
        end else begin
            n_pos = PW'(pos_inc);
        end
    end

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
            r_len <= LW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vig70_pkg::CFG_DIRECTION:  r_dir <= i_cfg_data[0];
                vig70_pkg::CFG_KEY_LENGTH: r_len <= i_cfg_data;
            endcase
        end
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (acc_key && slot_ok) begin
            r_key_mem[AW'(s_axis_tdata[7:0])] <=
                (in_idx < vig70_pkg::IDX_W'(vig70_pkg::ALPHA_SIZE)) ? in_idx : '0;
        end
        if (acc_data) begin
            r_shift <= r_key_mem[AW'(pos_eff)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_s1v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (acc_data) begin
                r_pos <= n_pos;
            end
            if (s_axis_tready) begin
                r_s1v <= acc_data;
            end
            if (out_en) begin
                r_ov <= r_s1v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_data) begin
            r_s1_idx <= in_idx;
            r_s1_ch  <= in_ch;
        end
        if (out_en && r_s1v) begin
            r_och  <= rot_hit ? rot_char : r_s1_ch;
            r_ohit <= rot_hit;
        end
    end

    assign rot_req.idx     = r_s1_idx;
    assign rot_req.shift   = r_shift;
    assign rot_req.decrypt = r_dir;

    vig70_rotate u_rotate (
        .i_req  (rot_req),
        .o_char (rot_char),
        .o_hit  (rot_hit)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_och;
    assign m_axis_tuser  = r_ohit;

    `VIG70_ASSERT_NEXT(a_data_enters_s1, acc_data, r_s1v, "data beat lost before stage 1")
    `VIG70_ASSERT_NEXT(a_key_no_result, acc_key, !r_s1v, "key write produced a result")
    `VIG70_ASSERT_NEXT(a_buffer_end_pos, acc_data && s_axis_tlast, r_pos == '0,
        "key position not cleared at buffer end")
    `VIG70_ASSERT_NEXT(a_result_held, r_ov && !m_axis_tready, r_ov, "stalled result dropped")
    `VIG70_ASSERT_NOW(a_miss_passthru, r_ov && !r_ohit,
        vig70_pkg::alpha_find(r_och) == vig70_pkg::IDX_W'(vig70_pkg::ALPHA_SIZE),
        "pass-through result found in the alphabet")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 70-symbol Vigenere cipher stream block.
// ---------------------------------------------------------------------------
// A directed table covers the alphabet ends, wrap-around in both directions,
// out-of-alphabet data and key characters, buffer end, key length zero,
// saturation and a key position left beyond a shortened key. The key store is
// then filled and random key/data traffic runs under several register
// settings with random gaps on both sides, one full-rate phase and one long
// output stall. Each result is checked against the directed table's value or an in-bench model.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int KEY_DEPTH   = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYC   = 4;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 250;
    localparam int STALL_CYC   = 300;

    localparam vig70_pkg::t_char SYMBOLS [vig70_pkg::ALPHA_SIZE] = '{
        16'h0041, 16'h2022, 16'h0042, 16'h0043, 16'h2206,
        16'h0044, 16'h0045, 16'h00A0, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C,
        16'h00A3, 16'h004D, 16'h004E, 16'h2014, 16'h004F,
        16'h201D, 16'h0050, 16'h0051, 16'h0052, 16'h0053,
        16'h00E5, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00E8, 16'h00D8,
        16'h0061, 16'h03C0, 16'h0062, 16'h0063, 16'h00CA,
        16'h0064, 16'h0065, 16'h00CD, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C,
        16'h2265, 16'h006D, 16'h006E, 16'h00D2, 16'h006F,
        16'h00DB, 16'h0070, 16'h0071, 16'h0072, 16'h0073,
        16'h00FA, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00FC, 16'h00F8
    };

    typedef struct packed {
        logic             hit;
        vig70_pkg::t_char ch;
    } t_cipher_out;

    typedef struct {
        bit                              is_cfg;
        logic                            func;
        logic [7:0]                      slot;
        vig70_pkg::t_char                ch;
        logic                            last;
        logic [vig70_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [vig70_pkg::LEN_W-1:0]     cfg_val;
        bit                              typed;
        t_cipher_out                     want;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [vig70_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [vig70_pkg::LEN_W-1:0]     i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [23:0]                     s_axis_tdata;   // [7:0] key_slot, [23:8] char_value
    logic                            s_axis_tuser;   // func
    logic                            s_axis_tlast;   // buffer_end
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [15:0]                     m_axis_tdata;   // [15:0] char_out
    logic                            m_axis_tuser;   // in_alphabet

    vigenere_70_symbol_cipher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Cipher model state
    logic [6:0]                  key_shift [KEY_DEPTH];
    int                          key_pos;
    logic                        decrypt_q;
    logic [vig70_pkg::LEN_W-1:0] key_len_q;

    t_cipher_out      cipher_q [$];
    bit               use_typed;
    t_cipher_out      typed_out;

    bit               gaps_on;
    bit               stall_req;
    int               errors;
    int               cycles;
    int               n_key;
    int               n_data;
    int               n_hit;
    int               n_cfg;
    t_row             plan [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("vigenere_70_symbol_cipher test failed");
            $finish;
        end
    end

    function automatic int symbol_index(input vig70_pkg::t_char c);
        for (int i = 0; i < vig70_pkg::ALPHA_SIZE; i++) begin
            if (SYMBOLS[i] == c) begin
                return i;
            end
        end
        return vig70_pkg::ALPHA_SIZE;
    endfunction

    function automatic vig70_pkg::t_char pick_char();
        if ($urandom_range(0, 99) < 65) begin
            return SYMBOLS[$urandom_range(0, vig70_pkg::ALPHA_SIZE - 1)];
        end
        return vig70_pkg::t_char'($urandom_range(0, 65535));
    endfunction

    // Updates key store / position; has_out is set for data beats.
    function automatic void cipher_beat(input logic func, input logic [7:0] slot,
                                        input vig70_pkg::t_char ch, input logic last,
                                        output t_cipher_out r, output bit has_out);
        int len;
        int pos;
        int k;
        int idx;
        r = '0;
        has_out = 1'b0;
        if (func == vig70_pkg::FUNC_KEY_WRITE) begin
            k = symbol_index(ch);
            key_shift[slot] = (k < vig70_pkg::ALPHA_SIZE) ? 7'(k) : 7'd0;
            return;
        end
        len = int'(key_len_q);
        if (len == 0) len = 1;
        if (len > KEY_DEPTH) len = KEY_DEPTH;
        pos = key_pos;
        if (pos >= len) pos = 0;
        idx = symbol_index(ch);
        if (idx < vig70_pkg::ALPHA_SIZE) begin
            if (decrypt_q)
                idx = (idx + vig70_pkg::ALPHA_SIZE - int'(key_shift[pos]))
                      % vig70_pkg::ALPHA_SIZE;
            else
                idx = (idx + int'(key_shift[pos])) % vig70_pkg::ALPHA_SIZE;
            r.ch  = SYMBOLS[idx];
            r.hit = 1'b1;
        end else begin
            r.ch  = ch;
            r.hit = 1'b0;
        end
        has_out = 1'b1;
        pos++;
        if (pos >= len || last) pos = 0;
        key_pos = pos;
    endfunction

    // Monitor: register writes, accepted input beats, result beats.
    always @(posedge i_clk) begin
        t_cipher_out pred;
        t_cipher_out got;
        t_cipher_out want;
        bit          has_out;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                n_cfg++;
                if (i_cfg_idx == vig70_pkg::CFG_DIRECTION)
                    decrypt_q = i_cfg_data[0];
                else if (i_cfg_idx == vig70_pkg::CFG_KEY_LENGTH)
                    key_len_q = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cipher_beat(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                            s_axis_tlast, pred, has_out);
                if (s_axis_tuser == vig70_pkg::FUNC_KEY_WRITE) n_key++;
                if (has_out) begin
                    n_data++;
                    if (pred.hit) n_hit++;
                    if (use_typed) begin
                        pred      = typed_out;
                        use_typed = 1'b0;
                    end
                    cipher_q.push_back(pred);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.ch  = m_axis_tdata;
                got.hit = m_axis_tuser;
                if (cipher_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got %h/%b",
                             $time, got.ch, got.hit);
                end else begin
                    want = cipher_q.pop_front();
                    if (got.ch !== want.ch) begin
                        errors++;
                        $display("%0t: char_out mismatch, expected %h, got %h",
                                 $time, want.ch, got.ch);
                    end
                    if (got.hit !== want.hit) begin
                        errors++;
                        $display("%0t: in_alphabet mismatch, expected %b, got %b",
                                 $time, want.hit, got.hit);
                    end
                end
            end
        end
    end

    // Output side: random backpressure, long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (STALL_CYC) @(negedge i_clk);
            end else begin
                m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    // Called and returns at a falling edge; tvalid is left high.
    task automatic send_beat(input logic func, input logic [7:0] slot,
                             input vig70_pkg::t_char ch, input logic last);
        while (gaps_on && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {ch, slot};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [vig70_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vig70_pkg::LEN_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_row key_row(input logic [7:0] slot, input vig70_pkg::t_char ch,
                                     input logic last);
        t_row r;
        r = '{default: '0};
        r.func = vig70_pkg::FUNC_KEY_WRITE;
        r.slot = slot;
        r.ch   = ch;
        r.last = last;
        return r;
    endfunction

    function automatic t_row data_row(input vig70_pkg::t_char ch, input logic last,
                                      input bit typed, input vig70_pkg::t_char want_ch,
                                      input logic want_hit);
        t_row r;
        r = '{default: '0};
        r.func      = vig70_pkg::FUNC_DATA;
        r.slot      = 8'($urandom_range(0, 255));
        r.ch        = ch;
        r.last      = last;
        r.typed     = typed;
        r.want.ch   = want_ch;
        r.want.hit  = want_hit;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [vig70_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [vig70_pkg::LEN_W-1:0] val);
        t_row r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    initial begin
        int   pick;
        t_row row;
        logic [7:0] slot;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        key_pos       = 0;
        decrypt_q     = 1'b0;
        key_len_q     = 9'd1;
        use_typed     = 1'b0;
        gaps_on       = 1'b1;
        stall_req     = 1'b0;
        errors        = 0;
        cycles        = 0;
        n_key         = 0;
        n_data        = 0;
        n_hit         = 0;
        n_cfg         = 0;
        foreach (key_shift[i]) key_shift[i] = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings (encrypt, key length 1), then decrypt with other key lengths.
        plan.push_back(key_row(8'd0, 16'h0041, 1'b0));
        plan.push_back(data_row(16'h0041, 1'b0, 1, 16'h0041, 1'b1));
        plan.push_back(data_row(16'h0000, 1'b0, 1, 16'h0000, 1'b0));
        plan.push_back(data_row(16'hFFFF, 1'b0, 1, 16'hFFFF, 1'b0));
        plan.push_back(key_row(8'd0, 16'hFFFF, 1'b0));     // non-alphabet key
        plan.push_back(data_row(16'h00F8, 1'b0, 1, 16'h00F8, 1'b1));
        plan.push_back(key_row(8'd0, 16'h00F8, 1'b0));     // largest shift
        plan.push_back(data_row(16'h0041, 1'b0, 1, 16'h00F8, 1'b1));
        plan.push_back(data_row(16'h2022, 1'b0, 1, 16'h0041, 1'b1));
        plan.push_back(key_row(8'd255, 16'h2022, 1'b1));   // tlast ignored
        plan.push_back(key_row(8'd1, 16'h0042, 1'b1));
        plan.push_back(data_row(16'h007A, 1'b1, 1, 16'h0079, 1'b1));
        plan.push_back(data_row(16'h00A0, 1'b0, 1, 16'h0045, 1'b1));
        plan.push_back(cfg_row(vig70_pkg::CFG_DIRECTION, 9'd1));
        plan.push_back(data_row(16'h0041, 1'b0, 1, 16'h2022, 1'b1));
        plan.push_back(data_row(16'h00F8, 1'b0, 1, 16'h0041, 1'b1));
        plan.push_back(cfg_row(vig70_pkg::CFG_KEY_LENGTH, 9'd2));
        plan.push_back(data_row(16'h0041, 1'b0, 0, '0, 1'b0));
        plan.push_back(data_row(16'h0041, 1'b0, 0, '0, 1'b0));
        plan.push_back(data_row(16'h0042, 1'b0, 0, '0, 1'b0));
        plan.push_back(cfg_row(vig70_pkg::CFG_KEY_LENGTH, 9'd0)); // position now past length
        plan.push_back(data_row(16'h0042, 1'b1, 0, '0, 1'b0));
        plan.push_back(cfg_row(vig70_pkg::CFG_KEY_LENGTH, 9'd511)); // saturates
        plan.push_back(data_row(16'h00FC, 1'b0, 0, '0, 1'b0));
        plan.push_back(cfg_row(vig70_pkg::CFG_DIRECTION, 9'd0));

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg) begin
                wait_idle();
                cfg_write(row.cfg_idx, row.cfg_val);
            end else begin
                if (row.typed) begin
                    typed_out = row.want;
                    use_typed = 1'b1;
                end
                send_beat(row.func, row.slot, row.ch, row.last);
            end
        end

        // Fill the whole key store so any length reads written entries only.
        for (int s = 0; s < KEY_DEPTH; s++)
            send_beat(vig70_pkg::FUNC_KEY_WRITE, 8'(s), pick_char(),
                      1'($urandom_range(0, 1)));

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= vig70_pkg::CFG_DIRECTION;
            i_cfg_data <= {8'($urandom_range(0, 255)), 1'(p % 2)};
            @(negedge i_clk);
            i_cfg_idx  <= vig70_pkg::CFG_KEY_LENGTH;
            case (p)
                0: i_cfg_data <= 9'd256;
                1: i_cfg_data <= 9'd1;
                2: i_cfg_data <= 9'($urandom_range(2, 16));
                3: i_cfg_data <= 9'd0;
                4: i_cfg_data <= 9'd511;
                5: i_cfg_data <= 9'($urandom_range(257, 510));
                default: i_cfg_data <= 9'($urandom_range(1, 256));
            endcase
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            gaps_on = (p != 2);
            if (p == 4) stall_req = 1'b1;

            for (int n = 0; n < PHASE_BEATS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    // Nearly half of the key writes hit the entry about to be read.
                    slot = (pick < 7) ? 8'(key_pos) : 8'($urandom_range(0, 255));
                    send_beat(vig70_pkg::FUNC_KEY_WRITE, slot, pick_char(),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_beat(vig70_pkg::FUNC_DATA, 8'($urandom_range(0, 255)),
                              pick_char(), $urandom_range(0, 11) == 0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d key writes and %0d data beats (%0d in the alphabet),",
                 n_key, n_data, n_hit);
        $display("with %0d register writes, random gaps, a full-rate phase and an output stall.",
                 n_cfg);
        if (errors == 0) begin
            $display("vigenere_70_symbol_cipher test passed");
        end else begin
            $display("vigenere_70_symbol_cipher test failed");
        end
        $finish;
    end

endmodule
